>>> rtl/core/mab_pkg.sv
// Shared types and constants for the mesh area and bounds block.
package mab_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIFF_WAIT,
        ST_EDGE,
        ST_EDGE_WAIT,
        ST_M1,
        ST_M1_WAIT,
        ST_M2,
        ST_M2_WAIT,
        ST_M3,
        ST_M3_WAIT,
        ST_RAD,
        ST_RAD_WAIT,
        ST_COMMIT
    } t_state;

    typedef enum logic [1:0] {
        MUL_DIFF,
        MUL_PT1,
        MUL_T23,
        MUL_M12
    } t_mul_op;

    typedef enum logic {
        SQ_EDGE,
        SQ_RAD
    } t_sq_op;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_AC = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int AREA_BITS = 63;
    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic       load;
        logic       mul_go;
        t_mul_op    mul_op;
        logic       sq_go;
        t_sq_op     sq_op;
        logic       acc_sq;
        logic       store_edge;
        logic       store_m1;
        logic       store_m2;
        logic       commit;
        logic       emit;
        logic [1:0] edge_sel;
        logic [1:0] axis_sel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic sq_done;
        logic last_mesh;
    } t_sts;

endpackage

>>> rtl/core/mab_mul.sv
// Serial shift-and-add multiplier, one multiplier bit per cycle.
module mab_mul #(
    parameter int MW = 54
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    output logic            o_done,
    output logic [2*MW-1:0] o_prod
);

    logic            r_busy;
    logic [2*MW-1:0] r_mcand;
    logic [MW-1:0]   r_mplier;
    logic [2*MW-1:0] r_prod;

    // finish early once the remaining multiplier bits are all zero
    assign o_done = r_busy && (r_mplier == '0);
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_mcand  <= (2*MW)'(i_a);
            r_mplier <= i_b;
            r_prod   <= '0;
        end else if (r_busy && (r_mplier != '0)) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

endmodule

>>> rtl/core/mab_sqrt.sv
// Restoring integer square root, two radicand bits per cycle.
module mab_sqrt #(
    parameter int RW = 108
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [RW-1:0]     i_x,
    output logic              o_done,
    output logic [RW/2-1:0]   o_root
);

    localparam int RTW = RW / 2;
    localparam int CW  = $clog2(RTW + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [RW-1:0]     r_x;
    logic [RTW+1:0]    r_rem;
    logic [RTW-1:0]    r_root;
    logic [RTW+1:0]    w_rem2;
    logic [RTW+1:0]    w_trial;

    assign o_done  = r_busy && (r_cnt == '0);
    assign o_root  = r_root;
    assign w_rem2  = {r_rem[RTW-1:0], r_x[RW-1 -: 2]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CW'(RTW);
        end else if (r_busy && (r_cnt != '0)) begin
            r_x   <= r_x << 2;
            r_cnt <= r_cnt - 1'b1;
            if (w_rem2 >= w_trial) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[RTW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[RTW-2:0], 1'b0};
            end
        end
    end

endmodule

>>> rtl/core/mab_dp.sv
// Datapath: vertex hold, edge and Heron arithmetic, mesh accumulators.
module mab_dp #(
    parameter int COORD_BITS = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mab_pkg::t_cmd             i_cmd,
    input  logic [9*COORD_BITS-1:0]   i_in_data,
    input  logic                      i_last_mesh,
    input  logic                      i_last_model,
    output mab_pkg::t_sts             o_sts,
    output logic [3*COORD_BITS-1:0]   o_box_min,
    output logic [3*COORD_BITS-1:0]   o_box_max,
    output logic [COUNT_BITS-1:0]     o_count,
    output logic [62:0]               o_area,
    output logic                      o_model_done
);
    import mab_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SQW = 2 * C + 2;
    localparam int EW  = C + 1;
    localparam int PW  = EW + 2;
    localparam int MW  = 2 * PW;
    localparam int RW  = 2 * MW;
    localparam int RTW = MW;
    localparam int AW  = RTW - 2;
    localparam logic [C-1:0] MOST_POS = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0] MOST_NEG = {1'b1, {(C-1){1'b0}}};

    logic signed [C-1:0] r_va [3];
    logic signed [C-1:0] r_vb [3];
    logic signed [C-1:0] r_vc [3];
    logic                r_last_mesh;
    logic                r_last_model;
    logic [SQW-1:0]      r_sum;
    logic [EW-1:0]       r_len [3];
    logic [MW-1:0]       r_m1;
    logic [MW-1:0]       r_m2;
    logic signed [C-1:0] r_box_min [3];
    logic signed [C-1:0] r_box_max [3];
    logic [COUNT_BITS-1:0] r_cnt;
    logic [AREA_BITS-1:0]  r_acc;

    logic signed [C-1:0] w_p [3];
    logic signed [C-1:0] w_q [3];
    logic signed [C:0]   w_d;
    logic [C-1:0]        w_abs;
    logic [PW-1:0]       w_per, w_t1, w_t2, w_t3;
    logic                w_bad;
    logic [MW-1:0]       w_mul_a, w_mul_b;
    logic                w_mul_done;
    logic [RW-1:0]       w_prod;
    logic [RW-1:0]       w_sq_x;
    logic                w_sq_done;
    logic [RTW-1:0]      w_root;
    logic [AW-1:0]       w_area_w;
    logic [AREA_BITS-1:0] w_area;
    logic [AREA_BITS:0]  w_acc_sum;
    logic [AREA_BITS-1:0] n_acc;
    logic signed [C-1:0] n_min [3];
    logic signed [C-1:0] n_max [3];
    logic [COUNT_BITS-1:0] n_cnt;

    // pick the two end points of the current edge
    always_comb begin
        case (i_cmd.edge_sel)
            EDGE_AB: begin w_p = r_va; w_q = r_vb; end
            EDGE_BC: begin w_p = r_vb; w_q = r_vc; end
            default: begin w_p = r_va; w_q = r_vc; end
        endcase
    end

    assign w_d   = {w_p[i_cmd.axis_sel][C-1], w_p[i_cmd.axis_sel]}
                 - {w_q[i_cmd.axis_sel][C-1], w_q[i_cmd.axis_sel]};
    assign w_abs = w_d[C] ? C'(-w_d) : C'(w_d);

    assign w_per = PW'(r_len[0]) + PW'(r_len[1]) + PW'(r_len[2]);
    assign w_t1  = PW'(r_len[1]) + PW'(r_len[2]) - PW'(r_len[0]);
    assign w_t2  = PW'(r_len[0]) + PW'(r_len[2]) - PW'(r_len[1]);
    assign w_t3  = PW'(r_len[0]) + PW'(r_len[1]) - PW'(r_len[2]);
    assign w_bad = (PW'(r_len[0]) > PW'(r_len[1]) + PW'(r_len[2]))
                || (PW'(r_len[1]) > PW'(r_len[0]) + PW'(r_len[2]))
                || (PW'(r_len[2]) > PW'(r_len[0]) + PW'(r_len[1]));

    always_comb begin
        case (i_cmd.mul_op)
            MUL_DIFF: begin w_mul_a = MW'(w_abs); w_mul_b = MW'(w_abs); end
            MUL_PT1:  begin w_mul_a = MW'(w_per); w_mul_b = MW'(w_t1);  end
            MUL_T23:  begin w_mul_a = MW'(w_t2);  w_mul_b = MW'(w_t3);  end
            default:  begin w_mul_a = r_m1;       w_mul_b = r_m2;       end
        endcase
    end

    assign w_sq_x = (i_cmd.sq_op == SQ_EDGE) ? RW'(r_sum) : w_prod;

    mab_mul #(.MW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    mab_sqrt #(.RW(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sq_go),
        .i_x     (w_sq_x),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // area is a quarter of the root, saturated; a broken triangle gives zero
    assign w_area_w  = w_root[RTW-1:2];
    assign w_area    = w_bad ? '0
                     : (w_area_w > AW'(AREA_MAX)) ? AREA_MAX : AREA_BITS'(w_area_w);
    assign w_acc_sum = {1'b0, r_acc} + {1'b0, w_area};
    assign n_acc     = w_acc_sum[AREA_BITS] ? AREA_MAX : w_acc_sum[AREA_BITS-1:0];
    assign n_cnt     = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_min[k] = r_box_min[k];
            n_max[k] = r_box_max[k];
            if (r_va[k] < n_min[k]) n_min[k] = r_va[k];
            if (r_vb[k] < n_min[k]) n_min[k] = r_vb[k];
            if (r_vc[k] < n_min[k]) n_min[k] = r_vc[k];
            if (r_va[k] > n_max[k]) n_max[k] = r_va[k];
            if (r_vb[k] > n_max[k]) n_max[k] = r_vb[k];
            if (r_vc[k] > n_max[k]) n_max[k] = r_vc[k];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_va[k] <= i_in_data[k*C +: C];
                r_vb[k] <= i_in_data[(3+k)*C +: C];
                r_vc[k] <= i_in_data[(6+k)*C +: C];
            end
            r_last_mesh  <= i_last_mesh;
            r_last_model <= i_last_model;
        end
        if (i_cmd.acc_sq) begin
            r_sum <= ((i_cmd.axis_sel == AXIS_X) ? '0 : r_sum) + SQW'(w_prod);
        end
        if (i_cmd.store_edge) begin
            case (i_cmd.edge_sel)
                EDGE_AB: r_len[0] <= EW'(w_root);
                EDGE_BC: r_len[1] <= EW'(w_root);
                default: r_len[2] <= EW'(w_root);
            endcase
        end
        if (i_cmd.store_m1) r_m1 <= MW'(w_prod);
        if (i_cmd.store_m2) r_m2 <= MW'(w_prod);
    end

    // mesh accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.commit && i_cmd.emit)) begin
            for (int k = 0; k < 3; k++) begin
                r_box_min[k] <= MOST_POS;
                r_box_max[k] <= MOST_NEG;
            end
            r_cnt <= '0;
            r_acc <= '0;
        end else if (i_cmd.commit) begin
            r_box_min <= n_min;
            r_box_max <= n_max;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
        end
    end

    assign o_sts.mul_done  = w_mul_done;
    assign o_sts.sq_done   = w_sq_done;
    assign o_sts.last_mesh = r_last_mesh;

    assign o_box_min    = {n_min[2], n_min[1], n_min[0]};
    assign o_box_max    = {n_max[2], n_max[1], n_max[0]};
    assign o_count      = n_cnt;
    assign o_area       = n_acc;
    assign o_model_done = r_last_model;

endmodule

>>> rtl/core/mab_ctrl.sv
// Controller: sequences edges, Heron products and roots for one triangle.
module mab_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    input  mab_pkg::t_sts i_sts,
    output logic          o_ready,
    output mab_pkg::t_cmd o_cmd
);
    import mab_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_edge, r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= EDGE_AB;
            r_axis <= AXIS_X;
        end else begin
            if (r_state == ST_IDLE) begin
                r_edge <= EDGE_AB;
                r_axis <= AXIS_X;
            end
            if (r_state == ST_DIFF_WAIT && i_sts.mul_done) begin
                r_axis <= (r_axis == AXIS_Z) ? AXIS_X : r_axis + 2'd1;
            end
            if (r_state == ST_EDGE_WAIT && i_sts.sq_done) begin
                r_edge <= r_edge + 2'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_DIFF;
            ST_DIFF:      n_state = ST_DIFF_WAIT;
            ST_DIFF_WAIT: if (i_sts.mul_done) begin
                n_state = (r_axis == AXIS_Z) ? ST_EDGE : ST_DIFF;
            end
            ST_EDGE:      n_state = ST_EDGE_WAIT;
            ST_EDGE_WAIT: if (i_sts.sq_done) begin
                n_state = (r_edge == EDGE_AC) ? ST_M1 : ST_DIFF;
            end
            ST_M1:        n_state = ST_M1_WAIT;
            ST_M1_WAIT:   if (i_sts.mul_done) n_state = ST_M2;
            ST_M2:        n_state = ST_M2_WAIT;
            ST_M2_WAIT:   if (i_sts.mul_done) n_state = ST_M3;
            ST_M3:        n_state = ST_M3_WAIT;
            ST_M3_WAIT:   if (i_sts.mul_done) n_state = ST_RAD;
            ST_RAD:       n_state = ST_RAD_WAIT;
            ST_RAD_WAIT:  if (i_sts.sq_done) n_state = ST_COMMIT;
            ST_COMMIT:    if (!i_sts.last_mesh || i_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_cmd            = '0;
        o_cmd.mul_op     = MUL_DIFF;
        o_cmd.sq_op      = SQ_EDGE;
        o_cmd.edge_sel   = r_edge;
        o_cmd.axis_sel   = r_axis;
        case (r_state)
            ST_IDLE: begin
                // hold ready low while reset is asserted
                o_ready    = i_rst_n;
                o_cmd.load = i_in_valid;
            end
            ST_DIFF:      o_cmd.mul_go = 1'b1;
            ST_DIFF_WAIT: o_cmd.acc_sq = i_sts.mul_done;
            ST_EDGE:      o_cmd.sq_go = 1'b1;
            ST_EDGE_WAIT: o_cmd.store_edge = i_sts.sq_done;
            ST_M1: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = MUL_PT1;
            end
            ST_M1_WAIT:   o_cmd.store_m1 = i_sts.mul_done;
            ST_M2: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = MUL_T23;
            end
            ST_M2_WAIT:   o_cmd.store_m2 = i_sts.mul_done;
            ST_M3: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = MUL_M12;
            end
            ST_RAD: begin
                o_cmd.sq_go = 1'b1;
                o_cmd.sq_op = SQ_RAD;
            end
            ST_COMMIT: begin
                o_cmd.commit = !i_sts.last_mesh || i_out_free;
                o_cmd.emit   = i_sts.last_mesh && i_out_free;
            end
            default: o_ready = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/mesh_area_and_bounds.sv
// Top level: per-mesh Heron area sum and bounding box of a triangle stream.
//
//  channel   | dir | tdata                               | tlast        | tuser
//  ----------+-----+-------------------------------------+--------------+--------------
//  s_axis    | in  | ax ay az bx by_coord bz cx cy cz    | last_of_mesh | last_of_model
//  m_axis    | out | min xyz, max xyz, count, area_sum   | -            | model_done
//
// One triangle at a time. Each takes nine serial squarings (one multiplier bit
// a cycle), two short Heron products, one long product and four restoring
// roots. The serial multiplier and the root unit set the time per triangle.
// Reset is synchronous, active low; it empties the accumulators and the output
// register and holds s_axis_tready low. A stalled output stalls only the closing
// triangle of a mesh: the result waits in the output register while the next
// triangle is taken.
module mesh_area_and_bounds #(
    parameter int COORD_BITS = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz from bit 0 up, zero padded
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    // last_of_model
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, triangle_count, area_sum
    // from bit 0 up, zero padded
    output logic [((6*COORD_BITS+COUNT_BITS+63+7)/8)*8-1:0] m_axis_tdata,
    // model_done
    output logic                 m_axis_tuser
);
    import mab_pkg::*;

    localparam int OUT_DW = ((6*COORD_BITS + COUNT_BITS + 63 + 7) / 8) * 8;

    t_cmd  w_cmd;
    t_sts  w_sts;
    logic  w_out_free;
    logic [3*COORD_BITS-1:0] w_box_min, w_box_max;
    logic [COUNT_BITS-1:0]   w_count;
    logic [62:0]             w_area;
    logic                    w_model_done;

    logic              r_m_valid;
    logic [OUT_DW-1:0] r_m_data;
    logic              r_m_user;

    // the output slot is free when empty or drained in this cycle
    assign w_out_free = !r_m_valid || m_axis_tready;

    mab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_ready    (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    mab_dp #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_data    (s_axis_tdata[9*COORD_BITS-1:0]),
        .i_last_mesh  (s_axis_tlast),
        .i_last_model (s_axis_tuser),
        .o_sts        (w_sts),
        .o_box_min    (w_box_min),
        .o_box_max    (w_box_max),
        .o_count      (w_count),
        .o_area       (w_area),
        .o_model_done (w_model_done)
    );

    // output register: hold the mesh result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_m_data <= OUT_DW'({w_area, w_count, w_box_max, w_box_min});
            r_m_user <= w_model_done;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_m_valid || m_axis_tready))
        else $error("mesh result overwritten");

    // one triangle in flight: taking one drops ready in the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second triangle taken while busy");

    // an emitted mesh always holds its closing triangle
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (w_count != '0))
        else $error("mesh emitted with zero triangles");

    // results only leave from the commit step of a closing triangle
    a_emit_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (w_cmd.commit && w_sts.last_mesh))
        else $error("emit outside a closing commit");

endmodule

>>> tb/mesh_area_and_bounds_tb.sv
// Testbench for the mesh area and bounds block: per-mesh box, count and Heron area checks.
`timescale 1ns / 1ps

module mesh_area_and_bounds_tb;
    import mab_pkg::*;

    localparam int CB = 24;
    localparam int NB = 24;
    localparam int IN_W = ((9*CB+7)/8)*8;
    localparam int OUT_W = ((6*CB+NB+63+7)/8)*8;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1000;
    localparam logic [CB-1:0] CRD_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CRD_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef struct {
        logic signed [CB-1:0] lo [3];
        logic signed [CB-1:0] hi [3];
        logic [NB-1:0]        count;
        logic [62:0]          area;
        logic                 done;
    } t_mesh_sum;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    // predictor state, mirrors the mesh accumulators
    logic signed [CB-1:0] box_lo [3];
    logic signed [CB-1:0] box_hi [3];
    logic [NB-1:0]        tri_cnt;
    logic [62:0]          area_acc;
    t_mesh_sum            pending_sums[$];
    int                   mismatches = 0;
    int                   quiet_cycles = 0;
    bit                   no_gaps = 0;
    int                   ready_hold = 0;

    mesh_area_and_bounds #(.COORD_BITS(CB), .COUNT_BITS(NB)) u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= x) root = cand;
        end
        return root;
    endfunction

    function automatic logic [63:0] edge_length(input logic signed [CB-1:0] p [3],
                                                input logic signed [CB-1:0] q [3]);
        logic [127:0] s;
        longint d;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            d = longint'(p[k]) - longint'(q[k]);
            if (d < 0) d = -d;
            s += 128'(d) * 128'(d);
        end
        return isqrt(s);
    endfunction

    // Heron area in Q63.0 (unsigned integer); zero when truncated edges break the triangle inequality
    function automatic logic [62:0] heron_area(input logic [63:0] la, lb, lc);
        logic [127:0] rad;
        logic [63:0] root;
        if (la > lb + lc || lb > la + lc || lc > la + lb) return '0;
        rad = 128'(la + lb + lc) * 128'(lb + lc - la) * 128'(la + lc - lb)
              * 128'(la + lb - lc);
        root = isqrt(rad) >> 2;
        if (root > {1'b0, AREA_MAX}) return AREA_MAX;
        return root[62:0];
    endfunction

    task automatic clear_mesh();
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = CRD_MAX;
            box_hi[k] = CRD_MIN;
        end
        tri_cnt = '0;
        area_acc = '0;
    endtask

    task automatic accumulate_triangle(input logic signed [CB-1:0] v [9],
                                       input logic lst, input logic mdl);
        logic signed [CB-1:0] a [3], b [3], c [3];
        logic [62:0] ar;
        t_mesh_sum r;
        for (int k = 0; k < 3; k++) begin
            a[k] = v[k]; b[k] = v[3+k]; c[k] = v[6+k];
        end
        ar = heron_area(edge_length(a, b), edge_length(b, c), edge_length(a, c));
        area_acc = (ar > AREA_MAX - area_acc) ? AREA_MAX : area_acc + ar;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                if (v[3*i+k] < box_lo[k]) box_lo[k] = v[3*i+k];
                if (v[3*i+k] > box_hi[k]) box_hi[k] = v[3*i+k];
            end
        if (tri_cnt != '1) tri_cnt++;
        if (lst) begin
            r.lo = box_lo; r.hi = box_hi;
            r.count = tri_cnt; r.area = area_acc; r.done = mdl;
            pending_sums.push_back(r);
            clear_mesh();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // hold the transaction until accepted, then fold it into the prediction
    task automatic send_triangle(input logic signed [CB-1:0] v [9],
                                 input logic lst, input logic mdl);
        int gap;
        logic [IN_W-1:0] data;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        data = '0;
        for (int i = 0; i < 9; i++) data[i*CB +: CB] = v[i];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tlast <= lst;
        s_axis_tuser <= mdl;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accumulate_triangle(v, lst, mdl);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord(input int style);
        case (style)
            0: return CB'($urandom);
            1: return CB'($urandom_range(600)) - CB'(300);
            default: return ($urandom_range(1)) ? CRD_MAX : CRD_MIN;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [CB-1:0] v [9];
        // full-scale corners: all vertices at the extremes
        foreach (v[i]) v[i] = CRD_MAX;
        send_triangle(v, 1'b1, 1'b0);
        foreach (v[i]) v[i] = CRD_MIN;
        send_triangle(v, 1'b1, 1'b1);
        // largest possible triangle
        v = '{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX,
              CRD_MIN, CRD_MAX, CRD_MAX};
        send_triangle(v, 1'b0, 1'b1);  // model flag without mesh close: ignored
        v = '{CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX,
              CRD_MAX, CRD_MIN, CRD_MAX};
        send_triangle(v, 1'b1, 1'b0);
        // truncated edges give a negative radicand
        v = '{0, 0, 0, 1, 1, 0, 3, 3, 0};
        send_triangle(v, 1'b1, 1'b0);
        // a plain right triangle, then a degenerate point
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        send_triangle(v, 1'b0, 1'b0);
        v = '{-5, 7, -9, -5, 7, -9, -5, 7, -9};
        send_triangle(v, 1'b1, 1'b1);
        for (int t = 0; t < 8; t++) begin
            foreach (v[i]) v[i] = rand_coord(t % 3);
            send_triangle(v, t == 7, 1'b0);
        end
    endtask

    task automatic test_random(input int n_items);
        logic signed [CB-1:0] v [9];
        int left_in_mesh, style;
        left_in_mesh = 0;
        for (int n = 0; n < n_items; n++) begin
            if (left_in_mesh == 0) begin
                left_in_mesh = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                        : $urandom_range(6, 1);
                style = $urandom_range(9) < 5 ? 0 : ($urandom_range(9) < 8 ? 1 : 2);
                no_gaps = ($urandom_range(7) == 0);
            end
            foreach (v[i]) v[i] = rand_coord(($urandom_range(9) == 0) ? 2 : style);
            left_in_mesh--;
            send_triangle(v, left_in_mesh == 0 || n == n_items - 1,
                          1'($urandom_range(1)));
            if (n == n_items / 2) wait_for_results();
        end
        no_gaps = 0;
    endtask

    // receiver: random stalls, mostly short
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_gaps) ready_hold <= pick_gap();
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_mesh_sum e;
            logic ok;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                e = pending_sums.pop_front();
                ok = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (m_axis_tdata[k*CB +: CB] !== e.lo[k]) ok = 1'b0;
                    if (m_axis_tdata[(3+k)*CB +: CB] !== e.hi[k]) ok = 1'b0;
                end
                if (m_axis_tdata[6*CB +: NB] !== e.count) ok = 1'b0;
                if (m_axis_tdata[6*CB+NB +: 63] !== e.area) ok = 1'b0;
                if (m_axis_tuser !== e.done) ok = 1'b0;
                if (!ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp lo %h %h %h hi %h %h %h cnt %h area %h done %b",
                                 e.lo[0], e.lo[1], e.lo[2], e.hi[0], e.hi[1], e.hi[2],
                                 e.count, e.area, e.done, "\n          got %h user %b",
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // watchdog: abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("mesh_area_and_bounds test failed");
            $finish;
        end
    end

    initial begin
        clear_mesh();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(2000);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("mesh_area_and_bounds test passed");
        else
            $display("mesh_area_and_bounds test failed");
        $finish;
    end

endmodule
